// File: hw/rtl/ctg_pkg.sv
// Shared types and constants of the color transition gradient core.
package ctg_pkg;

    localparam int COLOR_W           = 8;
    localparam int NUM_CH            = 4;
    localparam int STEPS_W           = 6;
    localparam int POS_W             = 6;
    localparam int QUOT_W            = COLOR_W + 1;
    localparam int DEFAULT_MAX_STEPS = 62;
    localparam int IN_DATA_W         = 2 * NUM_CH * COLOR_W;
    localparam int OUT_DATA_W        = 40;

    typedef logic [COLOR_W-1:0] chan_t;
    typedef chan_t [NUM_CH-1:0] color_t;

    // One run to generate: endpoints, step count and per-channel slope (floor quotient and
    // remainder of the channel difference divided by the step count)
    typedef struct packed {
        color_t                           from_color;
        color_t                           to_color;
        logic [STEPS_W-1:0]               steps;
        logic [NUM_CH-1:0][QUOT_W-1:0]    slope_quot;
        logic [NUM_CH-1:0][STEPS_W-1:0]   slope_rem;
    } job_t;

endpackage

// File: hw/rtl/ctg_front.sv
// Front end: accepts color pairs and computes the per-channel slope with a serial divider.
module ctg_front #(
    parameter int MAX_STEPS = ctg_pkg::DEFAULT_MAX_STEPS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [ctg_pkg::STEPS_W-1:0]     steps,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ctg_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            job_valid,
    input  logic                            job_ready,
    output ctg_pkg::job_t                   job
);
    import ctg_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [STEPS_W-1:0] MAX_S = STEPS_W'(MAX_STEPS);
    localparam int CNT_W = $clog2(COLOR_W);

    logic [1:0]                         state_reg, state_next;
    logic [CNT_W-1:0]                   cnt_reg, cnt_next;
    color_t                             from_reg, to_reg;
    logic [STEPS_W-1:0]                 steps_reg;
    logic [NUM_CH-1:0]                  neg_reg;
    logic [NUM_CH-1:0][COLOR_W-1:0]     mag_reg;
    logic [NUM_CH-1:0][STEPS_W-1:0]     part_reg;

    logic [STEPS_W-1:0]                 steps_eff;
    color_t                             in_from, in_to;
    logic [NUM_CH-1:0][QUOT_W-1:0]      diff;
    logic [NUM_CH-1:0][STEPS_W:0]       trial;
    logic [NUM_CH-1:0]                  fits;
    logic                               accept;

    // Clamp the step count into 1..MAX_STEPS
    always_comb
    begin
        if (steps == '0)
        begin
            steps_eff = STEPS_W'(1);
        end
        else if (steps > MAX_S)
        begin
            steps_eff = MAX_S;
        end
        else
        begin
            steps_eff = steps;
        end
    end

    // Unpack the beat and form the channel differences
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            in_from[c] = s_tdata[c*COLOR_W +: COLOR_W];
            in_to[c]   = s_tdata[(NUM_CH + c)*COLOR_W +: COLOR_W];
            diff[c]    = {1'b0, in_to[c]} - {1'b0, in_from[c]};
        end
    end

    // One restoring division step per cycle on each channel
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            trial[c] = {part_reg[c], mag_reg[c][COLOR_W-1]};
            fits[c]  = (trial[c] >= {1'b0, steps_reg});
        end
    end

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid && s_tready;
    assign job_valid = (state_reg == ST_HOLD);

    // Sequence: idle, divide, hold the result until the queue takes it
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_DIV;
                    cnt_next   = '0;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(COLOR_W - 1))
                begin
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (job_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Load operands on accept, shift the dividers while dividing
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            from_reg  <= in_from;
            to_reg    <= in_to;
            steps_reg <= steps_eff;
            for (int c = 0; c < NUM_CH; c++)
            begin
                neg_reg[c]  <= diff[c][QUOT_W-1];
                mag_reg[c]  <= diff[c][QUOT_W-1] ? COLOR_W'(-diff[c]) : diff[c][COLOR_W-1:0];
                part_reg[c] <= '0;
            end
        end
        else if (state_reg == ST_DIV)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                part_reg[c] <= fits[c] ? STEPS_W'(trial[c] - {1'b0, steps_reg})
                                       : trial[c][STEPS_W-1:0];
                mag_reg[c]  <= {mag_reg[c][COLOR_W-2:0], fits[c]};
            end
        end
    end

    // Turn the magnitude quotient into floor quotient and nonnegative remainder
    always_comb
    begin
        job.from_color = from_reg;
        job.to_color   = to_reg;
        job.steps      = steps_reg;
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (!neg_reg[c])
            begin
                job.slope_quot[c] = {1'b0, mag_reg[c]};
                job.slope_rem[c]  = part_reg[c];
            end
            else if (part_reg[c] == '0)
            begin
                job.slope_quot[c] = -{1'b0, mag_reg[c]};
                job.slope_rem[c]  = '0;
            end
            else
            begin
                job.slope_quot[c] = -({1'b0, mag_reg[c]} + QUOT_W'(1));
                job.slope_rem[c]  = steps_reg - part_reg[c];
            end
        end
    end

endmodule

// File: hw/rtl/ctg_fifo.sv
// Two-entry job queue between the front end and the run generator.
module ctg_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            wr_valid,
    output logic            wr_ready,
    input  ctg_pkg::job_t   wr_job,
    output logic            rd_valid,
    input  logic            rd_ready,
    output ctg_pkg::job_t   rd_job
);
    import ctg_pkg::*;

    job_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;
    logic       push, pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    // Store the incoming job
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_job;
        end
    end

endmodule

// File: hw/rtl/ctg_back.sv
// Run generator: walks one job and emits steps+2 colors, one beat per cycle unless the output stalls.
module ctg_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            job_valid,
    output logic                            job_ready,
    input  ctg_pkg::job_t                   job,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ctg_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import ctg_pkg::*;

    job_t                               job_reg;
    logic                               active_reg;
    logic [POS_W-1:0]                   pos_reg;
    logic [NUM_CH-1:0][QUOT_W-1:0]      acc_q_reg;
    logic [NUM_CH-1:0][STEPS_W-1:0]     acc_r_reg;

    logic                               m_tvalid_reg;
    color_t                             out_color_reg;
    logic [POS_W-1:0]                   out_pos_reg;
    logic                               out_last_reg;

    logic                               emit;
    logic                               is_last;
    color_t                             cur_color;
    logic [NUM_CH-1:0][STEPS_W:0]       r_sum;
    logic [NUM_CH-1:0]                  wrap;

    assign job_ready = !active_reg;
    assign emit      = active_reg && (!m_tvalid_reg || m_tready);
    assign is_last   = (pos_reg == POS_W'(job_reg.steps + STEPS_W'(1)));

    // Select the color of the current entry and the remainder carry for the next
    always_comb
    begin
        for (int c = 0; c < NUM_CH; c++)
        begin
            if (pos_reg == '0)
            begin
                cur_color[c] = job_reg.from_color[c];
            end
            else if (is_last)
            begin
                cur_color[c] = job_reg.to_color[c];
            end
            else
            begin
                cur_color[c] = job_reg.from_color[c] + acc_q_reg[c][COLOR_W-1:0];
            end
            r_sum[c] = {1'b0, acc_r_reg[c]} + {1'b0, job_reg.slope_rem[c]};
            wrap[c]  = (r_sum[c] >= {1'b0, job_reg.steps});
        end
    end

    // Control: take a job when idle, drop it after its last beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (job_valid && !active_reg)
            begin
                active_reg <= 1'b1;
            end
            else if (emit && is_last)
            begin
                active_reg <= 1'b0;
            end
            if (emit)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    // Datapath: load the job, step the accumulators, fill the output register
    always_ff @(posedge clk)
    begin
        if (job_valid && !active_reg)
        begin
            job_reg   <= job;
            pos_reg   <= '0;
            acc_q_reg <= '0;
            acc_r_reg <= '0;
        end
        else if (emit)
        begin
            pos_reg <= pos_reg + POS_W'(1);
            for (int c = 0; c < NUM_CH; c++)
            begin
                acc_q_reg[c] <= acc_q_reg[c] + job_reg.slope_quot[c] + QUOT_W'(wrap[c]);
                acc_r_reg[c] <= wrap[c] ? STEPS_W'(r_sum[c] - {1'b0, job_reg.steps})
                                        : r_sum[c][STEPS_W-1:0];
            end
        end
        if (emit)
        begin
            out_color_reg <= cur_color;
            out_pos_reg   <= pos_reg;
            out_last_reg  <= is_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {(OUT_DATA_W - NUM_CH*COLOR_W - POS_W)'(0), out_pos_reg, out_color_reg};

endmodule

// File: hw/rtl/color_transition_gradient_core.sv
// Color transition gradient core: top level with step register, front end, queue and back end.
//
// Each input beat carries a pair of RGBA colors; the core answers with a run of steps+2
// output beats: the start color, steps interpolated colors from + floor((to-from)*j/steps),
// and the end color, which closes the run with tlast set. The steps register is clamped to
// 1..MAX_STEPS when a pair is taken. A pair occupies the front end while it is accepted,
// while a bit-serial divider forms each channel's slope and until it is handed off into a
// two-entry queue; the front end can then accept the next pair while the back end emits
// steps+2 beats, one beat per cycle while the output is not stalled, and then loads the
// next job. The front end sets the pace for steps below 7, the back end for larger step
// counts. Output stalls hold the back end.
module color_transition_gradient_core #(
    parameter int MAX_STEPS = ctg_pkg::DEFAULT_MAX_STEPS
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wen,
    input  logic [ctg_pkg::STEPS_W-1:0]     cfg_wdata,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // from_red, from_green, from_blue, from_alpha, to_red, to_green, to_blue, to_alpha
    input  logic [ctg_pkg::IN_DATA_W-1:0]   s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_red, out_green, out_blue, out_alpha, position, zero pad
    output logic [ctg_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic                            m_tlast
);
    import ctg_pkg::*;

    logic [STEPS_W-1:0] steps_reg;
    logic               fq_valid, fq_ready, qb_valid, qb_ready;
    job_t               fq_job, qb_job;

    // Hold the step count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_W'(1);
        end
        else if (cfg_wen)
        begin
            steps_reg <= cfg_wdata;
        end
    end

    ctg_front #(
        .MAX_STEPS (MAX_STEPS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .steps     (steps_reg),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .job_valid (fq_valid),
        .job_ready (fq_ready),
        .job       (fq_job)
    );

    ctg_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fq_valid),
        .wr_ready (fq_ready),
        .wr_job   (fq_job),
        .rd_valid (qb_valid),
        .rd_ready (qb_ready),
        .rd_job   (qb_job)
    );

    ctg_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (qb_valid),
        .job_ready (qb_ready),
        .job       (qb_job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

// File: test/tb_color_transition_gradient_core.sv
// Testbench for the color transition gradient core: RGBA pair stream in, gradient beats out.
`timescale 1ns / 100ps

module tb_color_transition_gradient_core;

    import ctg_pkg::*;

    localparam int MAX_STEPS        = DEFAULT_MAX_STEPS;
    localparam int SINK_HOLD_CYCLES = 300;
    localparam int WATCHDOG_LIMIT   = 3000;
    localparam int SETTLE_CYCLES    = 4;
    localparam int TAIL_CYCLES      = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int RESET_CYCLES     = 12;

    typedef enum int {SINK_OPEN, SINK_COIN, SINK_PATTERN, SINK_SPARSE} sink_mode_t;
    typedef enum int {PAIR_ANY, PAIR_NEAR, PAIR_FLAT, PAIR_RAIL} pair_kind_t;

    // One expected gradient entry
    typedef struct {
        color_t           color;
        logic [POS_W-1:0] pos;
        logic             last;
    } grad_entry_t;

    logic                  clk;
    logic                  rst_n     = 1'b0;
    logic                  cfg_wen   = 1'b0;
    logic [STEPS_W-1:0]    cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    // from_red, from_green, from_blue, from_alpha, to_red, to_green, to_blue, to_alpha
    logic [IN_DATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    // out_red, out_green, out_blue, out_alpha, position, zero pad
    logic [OUT_DATA_W-1:0] m_tdata;
    logic                  m_tlast;

    grad_entry_t pending_colors[$];
    int          step_count      = 1;
    int          mismatches      = 0;
    int          pairs_sent      = 0;
    int          beats_checked   = 0;
    int          step_writes     = 0;
    int          sink_holds      = 0;
    int          burst_left      = 1;
    int          burst_max       = 8;
    int          gap_max         = 6;
    bit          sink_hold_req   = 1'b0;
    sink_mode_t  sink_mode       = SINK_COIN;

    color_transition_gradient_core #(
        .MAX_STEPS (MAX_STEPS)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Clamp a raw register value into the usable step range
    function automatic int eff_steps(input int value);
        int s;
        s = value & 63;
        if (s < 1)
            s = 1;
        if (s > MAX_STEPS)
            s = MAX_STEPS;
        return s;
    endfunction

    // from + floor((to - from) * j / s), exact in integers
    function automatic int lerp_chan(input int from_v, input int to_v, input int j, input int s);
        int num;
        int q;
        num = (to_v - from_v) * j;
        if (num >= 0)
            q = num / s;
        else
            q = -((-num + s - 1) / s);
        return (from_v + q) & 255;
    endfunction

    // Count one mismatch and tell whether it is still reported in full
    function automatic bit report_next();
        mismatches++;
        return (mismatches <= MAX_REPORTS);
    endfunction

    // Queue the whole expected run of one accepted pair
    task automatic predict_run(input color_t from_c, input color_t to_c);
        grad_entry_t entry;
        int          s;
        int          v;
        s = eff_steps(step_count);
        for (int j = 0; j <= s + 1; j++)
        begin
            for (int c = 0; c < NUM_CH; c++)
            begin
                if (j == 0)
                    v = int'(from_c[c]);
                else if (j == s + 1)
                    v = int'(to_c[c]);
                else
                    v = lerp_chan(int'(from_c[c]), int'(to_c[c]), j, s);
                entry.color[c] = COLOR_W'(v);
            end
            entry.pos  = POS_W'(j);
            entry.last = (j == s + 1);
            pending_colors.push_back(entry);
        end
    endtask

    // Build one color pair of the requested kind
    task automatic make_pair(input pair_kind_t kind, output color_t from_c,
                             output color_t to_c);
        int base;
        int peer;
        for (int c = 0; c < NUM_CH; c++)
        begin
            base = int'($urandom_range(255, 0));
            case (kind)
                PAIR_ANY:
                    peer = int'($urandom_range(255, 0));
                PAIR_NEAR:
                begin
                    peer = base + int'($urandom_range(6, 0)) - 3;
                    if (peer < 0)
                        peer = 0;
                    if (peer > 255)
                        peer = 255;
                end
                PAIR_FLAT:
                    peer = base;
                PAIR_RAIL:
                begin
                    base = ($urandom_range(1, 0) == 1) ? 255 : 0;
                    peer = 255 - base;
                end
                default:
                    peer = int'($urandom_range(255, 0));
            endcase
            from_c[c] = COLOR_W'(base);
            to_c[c]   = COLOR_W'(peer);
        end
    endtask

    // Offer one pair, hold it until accepted, insert a gap at the end of a burst
    task automatic send_pair(input color_t from_c, input color_t to_c);
        int gap;
        if (burst_left <= 0)
        begin
            gap = int'($urandom_range(gap_max, 1));
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = int'($urandom_range(burst_max, 1));
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {to_c, from_c};
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        predict_run(from_c, to_c);
        pairs_sent++;
        burst_left--;
    endtask

    // Send a number of pairs of one kind
    task automatic send_random(input int count, input pair_kind_t kind);
        color_t from_c;
        color_t to_c;
        for (int i = 0; i < count; i++)
        begin
            make_pair(kind, from_c, to_c);
            send_pair(from_c, to_c);
        end
    endtask

    // Drop the input and wait until every expected beat has arrived
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        while (pending_colors.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Write the step register; only called with nothing in flight
    task automatic write_steps(input int value);
        cfg_wen   <= 1'b1;
        cfg_wdata <= STEPS_W'(value);
        @(posedge clk);
        cfg_wen   <= 1'b0;
        step_count = value & 63;
        step_writes++;
        @(posedge clk);
    endtask

    // Default step count straight out of reset
    task automatic test_reset_default();
        send_random(8, PAIR_ANY);
        wait_drained();
    endtask

    // Zero and oversized step counts are clamped
    task automatic test_step_clamp();
        write_steps(0);
        send_random(4, PAIR_ANY);
        wait_drained();
        write_steps(63);
        send_random(3, PAIR_RAIL);
        wait_drained();
    endtask

    // A spread of legal step counts
    task automatic test_step_sweep();
        int sweep_vals [7];
        sweep_vals = '{2, 3, 5, 7, 13, 31, 62};
        foreach (sweep_vals[i])
        begin
            write_steps(sweep_vals[i]);
            send_random(4, PAIR_ANY);
            wait_drained();
        end
    endtask

    // Full-scale, near-equal and equal endpoints
    task automatic test_extreme_pairs();
        write_steps(62);
        send_random(4, PAIR_RAIL);
        wait_drained();
        write_steps(5);
        send_random(4, PAIR_NEAR);
        send_random(4, PAIR_FLAT);
        wait_drained();
    endtask

    // Pairs offered with no gap into an open sink
    task automatic test_back_to_back();
        sink_mode  = SINK_OPEN;
        burst_max  = 32;
        burst_left = 32;
        write_steps(1);
        send_random(15, PAIR_ANY);
        wait_drained();
        burst_max = 8;
        sink_mode = SINK_COIN;
    endtask

    // Long output stall while pairs keep coming, so the input backs up
    task automatic test_output_stall();
        write_steps(20);
        sink_mode     = SINK_COIN;
        sink_hold_req = 1'b1;
        send_random(8, PAIR_ANY);
        wait_drained();
    endtask

    // Random step counts, pair kinds and sink patterns
    task automatic test_random_mix();
        for (int r = 0; r < 4; r++)
        begin
            write_steps(int'($urandom_range(63, 0)));
            sink_mode = sink_mode_t'($urandom_range(3, 1));
            send_random(8, pair_kind_t'($urandom_range(3, 0)));
            wait_drained();
        end
        sink_mode = SINK_COIN;
    endtask

    // Receiver: own stall pattern, plus a long hold on request
    initial
    begin : sink_drive
        int sink_phase;
        sink_phase = 0;
        forever
        begin
            @(posedge clk);
            sink_phase++;
            if (sink_hold_req)
            begin
                sink_hold_req = 1'b0;
                sink_holds++;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                case (sink_mode)
                    SINK_OPEN:    m_tready <= 1'b1;
                    SINK_COIN:    m_tready <= 1'($urandom_range(1, 0));
                    SINK_PATTERN: m_tready <= ((sink_phase % 7) < 4);
                    SINK_SPARSE:  m_tready <= ($urandom_range(3, 0) == 0);
                    default:      m_tready <= 1'b1;
                endcase
            end
        end
    end

    // Check each output beat against the expected run
    initial
    begin : result_check
        grad_entry_t      exp_e;
        color_t           got_color;
        logic [POS_W-1:0] got_pos;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                got_color = m_tdata[NUM_CH*COLOR_W-1:0];
                got_pos   = m_tdata[NUM_CH*COLOR_W +: POS_W];
                beats_checked++;
                if (pending_colors.size() == 0)
                begin
                    if (report_next())
                        $display("mismatch at %0t: unexpected beat color %h pos %0d last %0b",
                                 $realtime, got_color, got_pos, m_tlast);
                end
                else
                begin
                    exp_e = pending_colors.pop_front();
                    if (got_color !== exp_e.color || got_pos !== exp_e.pos ||
                        m_tlast !== exp_e.last)
                    begin
                        if (report_next())
                            $display({"mismatch at %0t: expected color %h pos %0d last %0b,",
                                      " got color %h pos %0d last %0b"},
                                     $realtime, exp_e.color, exp_e.pos, exp_e.last,
                                     got_color, got_pos, m_tlast);
                    end
                end
            end
        end
    end

    // Stop the run when nothing is accepted for too long
    initial
    begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        forever
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wen)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("no beat accepted for %0d cycles, %0d beats still expected",
                         idle_cycles, pending_colors.size());
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // Test sequence
    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_default();
        test_step_clamp();
        test_step_sweep();
        test_extreme_pairs();
        test_back_to_back();
        test_output_stall();
        test_random_mix();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_colors.size() != 0)
        begin
            $display("%0d expected beats never arrived", pending_colors.size());
        end
        $display("ran %0d color pairs into %0d gradient beats over %0d step register writes,",
                 pairs_sent, beats_checked, step_writes);
        $display("with clamped step counts, bursts, %0d long output stalls and full drains",
                 sink_holds);
        if (mismatches == 0 && pending_colors.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
